/* rtl/polyline_proximity_test_unit_macros.svh */
// Assertion macros for the RTL of the polyline proximity test unit; ppt_back.sv uses them.
`ifndef POLYLINE_PROXIMITY_TEST_UNIT_MACROS_SVH
`define POLYLINE_PROXIMITY_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PPT_ASSERT_ANY(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PPT_ASSERT(name, prop)
`define PPT_ASSERT_ANY(name, prop)
`endif
`endif

/* rtl/ppt_pkg.sv */
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int TOL_W      = 12;
  localparam int T2_W       = 2 * TOL_W;
  localparam int MUL_W      = ((DIFF_W > T2_W) ? DIFF_W : T2_W) + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ABS_W      = 2 * DIFF_W - 1;
  localparam int DOT_W      = ABS_W + 1;
  localparam int ACC_BASE   = (PROD_W > 2 * ABS_W) ? PROD_W : 2 * ABS_W;
  localparam int ACC_W      = ((ACC_BASE > T2_W + ABS_W) ? ACC_BASE : T2_W + ABS_W) + 2;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = '0;
  localparam logic [TOL_W-1:0]     TOL_RESET     = 12'd32;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_SEG,
    JOB_FLUSH
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic      last;
    diff_t     vx;
    diff_t     vy;
    diff_t     wx;
    diff_t     wy;
    diff_t     dx;
    diff_t     dy;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_C1A,
    B_C1B,
    B_C2A,
    B_C2B,
    B_DECIDE,
    B_W1,
    B_W2,
    B_D1,
    B_D2,
    B_X1,
    B_X2,
    B_S0,
    B_S1,
    B_S2,
    B_T0,
    B_T1,
    B_CHECK,
    B_EMIT
  } back_state_t;

endpackage

/* rtl/ppt_front.sv */
`timescale 1ns / 1ps
module ppt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 in_cmd,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic                                 in_last,
  input  ppt_pkg::q_status_t                   q_status,
  output logic                                 job_push,
  output ppt_pkg::job_t                        job
);
  import ppt_pkg::*;

  logic signed [COORD_BITS-1:0] query_x_r, query_x_nxt;
  logic signed [COORD_BITS-1:0] query_y_r, query_y_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic signed [COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  logic                         have_prev_r, have_prev_nxt;
  logic                         accept;
  diff_t                        xe, ye, pxe, pye, qxe, qye;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  assign xe  = DIFF_W'(in_coord_x);
  assign ye  = DIFF_W'(in_coord_y);
  assign pxe = DIFF_W'(prev_x_r);
  assign pye = DIFF_W'(prev_y_r);
  assign qxe = DIFF_W'(query_x_r);
  assign qye = DIFF_W'(query_y_r);

  always_comb begin
    job.last = in_last;
    job.vx   = xe - pxe;
    job.vy   = ye - pye;
    job.wx   = qxe - pxe;
    job.wy   = qye - pye;
    job.dx   = qxe - xe;
    job.dy   = qye - ye;
    if (in_cmd == CMD_QUERY) begin
      job.kind = JOB_CLEAR;
    end else if (have_prev_r) begin
      job.kind = JOB_SEG;
    end else begin
      job.kind = JOB_FLUSH;
    end
    job_push = accept && ((in_cmd == CMD_QUERY) || have_prev_r || in_last);
  end

  always_comb begin
    query_x_nxt   = query_x_r;
    query_y_nxt   = query_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_cmd == CMD_QUERY) begin
        query_x_nxt = in_coord_x;
        query_y_nxt = in_coord_y;
      end else begin
        prev_x_nxt    = in_coord_x;
        prev_y_nxt    = in_coord_y;
        have_prev_nxt = !in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r   <= '0;
      query_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
    end else begin
      query_x_r   <= query_x_nxt;
      query_y_r   <= query_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

/* rtl/ppt_queue.sv */
`timescale 1ns / 1ps
module ppt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ppt_pkg::job_t      wr_job,
  input  logic               rd_en,
  output ppt_pkg::job_t      rd_job,
  output ppt_pkg::q_status_t status
);
  import ppt_pkg::*;

  job_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                do_wr, do_rd;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_job       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/ppt_back.sv */
`timescale 1ns / 1ps
`include "polyline_proximity_test_unit_macros.svh"
module ppt_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppt_pkg::q_status_t       q_status,
  input  ppt_pkg::job_t            q_job,
  output logic                     q_pop,
  input  logic [ppt_pkg::T2_W-1:0] t2,
  input  logic                     pop,
  output logic                     empty,
  output logic                     out_hit
);
  import ppt_pkg::*;

  back_state_t              state_r, state_nxt;
  job_t                     job_r, job_nxt;
  logic signed [DOT_W-1:0]  c1_r, c1_nxt;
  logic [ABS_W-1:0]         c2_r, c2_nxt;
  logic signed [DOT_W-1:0]  cross_r, cross_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     hit_r, hit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r, out_hit_nxt;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DOT_W-1:0]  prod_dot;
  logic signed [ACC_W-1:0]  pe;
  logic signed [ACC_W-1:0]  t2_acc;
  logic signed [DOT_W-1:0]  c2_s;
  logic signed [DOT_W-1:0]  cross_abs;
  logic [ABS_W-1:0]         ac;
  logic [DIFF_W-1:0]        a0, c2_lo;
  logic [ABS_W-DIFF_W-1:0]  a1, c2_hi;
  logic                     emit_ok;
  logic                     near_start, past_end;

  assign cross_abs  = cross_r[DOT_W-1] ? -cross_r : cross_r;
  assign ac         = cross_abs[ABS_W-1:0];
  assign a0         = ac[DIFF_W-1:0];
  assign a1         = ac[ABS_W-1:DIFF_W];
  assign c2_lo      = c2_r[DIFF_W-1:0];
  assign c2_hi      = c2_r[ABS_W-1:DIFF_W];
  assign c2_s       = DOT_W'(c2_r);
  assign t2_acc     = ACC_W'(t2);
  assign near_start = c1_r[DOT_W-1] || (c1_r == '0) || (c2_r == '0);
  assign past_end   = (c1_r >= c2_s);
  assign emit_ok    = !out_valid_r || pop;
  assign empty      = !out_valid_r;
  assign out_hit    = out_hit_r;

  // One shared multiplier; the state picks its operands.
  always_comb begin
    case (state_r)
      B_C1A: begin
        op_a = MUL_W'(job_r.vx);
        op_b = MUL_W'(job_r.wx);
      end
      B_C1B: begin
        op_a = MUL_W'(job_r.vy);
        op_b = MUL_W'(job_r.wy);
      end
      B_C2A: begin
        op_a = MUL_W'(job_r.vx);
        op_b = MUL_W'(job_r.vx);
      end
      B_C2B: begin
        op_a = MUL_W'(job_r.vy);
        op_b = MUL_W'(job_r.vy);
      end
      B_W1: begin
        op_a = MUL_W'(job_r.wx);
        op_b = MUL_W'(job_r.wx);
      end
      B_W2: begin
        op_a = MUL_W'(job_r.wy);
        op_b = MUL_W'(job_r.wy);
      end
      B_D1: begin
        op_a = MUL_W'(job_r.dx);
        op_b = MUL_W'(job_r.dx);
      end
      B_D2: begin
        op_a = MUL_W'(job_r.dy);
        op_b = MUL_W'(job_r.dy);
      end
      B_X1: begin
        op_a = MUL_W'(job_r.vx);
        op_b = MUL_W'(job_r.wy);
      end
      B_X2: begin
        op_a = MUL_W'(job_r.vy);
        op_b = MUL_W'(job_r.wx);
      end
      B_S0: begin
        op_a = MUL_W'(a0);
        op_b = MUL_W'(a0);
      end
      B_S1: begin
        op_a = MUL_W'(a0);
        op_b = MUL_W'(a1);
      end
      B_S2: begin
        op_a = MUL_W'(a1);
        op_b = MUL_W'(a1);
      end
      B_T0: begin
        op_a = MUL_W'(t2);
        op_b = MUL_W'(c2_lo);
      end
      B_T1: begin
        op_a = MUL_W'(t2);
        op_b = MUL_W'(c2_hi);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_dot = prod[DOT_W-1:0];
  assign pe       = ACC_W'(prod);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          case (q_job.kind)
            JOB_SEG:   state_nxt = B_C1A;
            JOB_FLUSH: state_nxt = B_EMIT;
            default:   state_nxt = B_IDLE;
          endcase
        end
      end
      B_C1A:  state_nxt = B_C1B;
      B_C1B:  state_nxt = B_C2A;
      B_C2A:  state_nxt = B_C2B;
      B_C2B:  state_nxt = B_DECIDE;
      B_DECIDE: begin
        if (near_start) begin
          state_nxt = B_W1;
        end else if (past_end) begin
          state_nxt = B_D1;
        end else begin
          state_nxt = B_X1;
        end
      end
      B_W1:   state_nxt = B_W2;
      B_W2:   state_nxt = B_CHECK;
      B_D1:   state_nxt = B_D2;
      B_D2:   state_nxt = B_CHECK;
      B_X1:   state_nxt = B_X2;
      B_X2:   state_nxt = B_S0;
      B_S0:   state_nxt = B_S1;
      B_S1:   state_nxt = B_S2;
      B_S2:   state_nxt = B_T0;
      B_T0:   state_nxt = B_T1;
      B_T1:   state_nxt = B_CHECK;
      B_CHECK: state_nxt = job_r.last ? B_EMIT : B_IDLE;
      B_EMIT: state_nxt = emit_ok ? B_IDLE : B_EMIT;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    job_nxt       = job_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    cross_nxt     = cross_r;
    acc_nxt       = acc_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          c1_nxt    = '0;
          c2_nxt    = '0;
          cross_nxt = '0;
          if (q_job.kind == JOB_CLEAR) begin
            hit_nxt = 1'b0;
          end
        end
      end
      B_C1A, B_C1B: c1_nxt = c1_r + prod_dot;
      B_C2A, B_C2B: c2_nxt = c2_r + prod[ABS_W-1:0];
      B_DECIDE: acc_nxt = (near_start || past_end) ? -t2_acc : '0;
      B_W1, B_W2, B_D1, B_D2, B_S0: acc_nxt = acc_r + pe;
      B_X1: cross_nxt = cross_r + prod_dot;
      B_X2: cross_nxt = cross_r - prod_dot;
      B_S1: acc_nxt = acc_r + (pe <<< (DIFF_W + 1));
      B_S2: acc_nxt = acc_r + (pe <<< (2 * DIFF_W));
      B_T0: acc_nxt = acc_r - pe;
      B_T1: acc_nxt = acc_r - (pe <<< DIFF_W);
      B_CHECK: begin
        if (acc_r[ACC_W-1] || (acc_r == '0)) begin
          hit_nxt = 1'b1;
        end
      end
      B_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    c1_r      <= c1_nxt;
    c2_r      <= c2_nxt;
    cross_r   <= cross_nxt;
    acc_r     <= acc_nxt;
    out_hit_r <= out_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PPT_ASSERT(a_interior_case, (state_r == B_X1) |-> (!near_start && (c1_r < c2_s)))
  `PPT_ASSERT(a_emit_waits, (state_r == B_EMIT && !emit_ok) |=> (state_r == B_EMIT))
  `PPT_ASSERT(a_emit_loads, (state_r == B_EMIT && emit_ok) |=> (out_valid_r && (out_hit_r == $past(hit_r))))
  `PPT_ASSERT(a_pop_idle_only, q_pop |-> (state_r == B_IDLE && !q_status.empty))

endmodule

/* rtl/polyline_proximity_test_unit.sv */
`timescale 1ns / 1ps
// Polyline proximity test. A query item (cmd 0) loads the query point and clears the hit
// flag; vertex items (cmd 1) each close a segment with the vertex before, and the vertex
// marked last delivers one beat on the result side carrying the hit flag. The front end
// accepts an item per cycle while its two-entry job queue has room. The back end owns a
// single 25 by 25 multiplier and works on one segment at a time: dot and length products,
// then the squared endpoint distance when the nearest point is an endpoint, or the cross
// product, its square and the tolerance product when it is interior. The tolerance register
// sits at byte address 0 and compares against the distance in 1/16 pixel, inclusive.
module polyline_proximity_test_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  in_cmd,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic                                  in_last,
  input  logic                                  pop,
  output logic                                  empty,
  output logic                                  out_hit,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ppt_pkg::ADDR_W-1:0]            paddr,
  input  logic [ppt_pkg::DATA_W-1:0]            pwdata,
  output logic [ppt_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);
  import ppt_pkg::*;

  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic [T2_W-1:0]  t2_r, t2_nxt;
  logic             tol_sel, tol_wr;
  logic             job_push, q_pop;
  job_t             front_job, q_job;
  q_status_t        q_status;

  assign pready  = 1'b1;
  assign tol_sel = (paddr[ADDR_W-1:2] == REG_TOLERANCE);
  assign tol_wr  = psel && penable && pwrite && pready && tol_sel;
  assign prdata  = tol_sel ? DATA_W'(tol_r) : '0;

  always_comb begin
    tol_nxt = tol_r;
    t2_nxt  = t2_r;
    if (tol_wr) begin
      tol_nxt = pwdata[TOL_W-1:0];
      t2_nxt  = pwdata[TOL_W-1:0] * pwdata[TOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      t2_r  <= TOL_RESET * TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
      t2_r  <= t2_nxt;
    end
  end

  ppt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_cmd     (in_cmd),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_last    (in_last),
    .q_status   (q_status),
    .job_push   (job_push),
    .job        (front_job)
  );

  ppt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (front_job),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .status (q_status)
  );

  ppt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .t2       (t2_r),
    .pop      (pop),
    .empty    (empty),
    .out_hit  (out_hit)
  );

endmodule

/* tb/ppt_hit_checker.sv */
`timescale 1ns / 1ps
module ppt_hit_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic                                  full,
  input  logic                                  in_cmd,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic                                  in_last,
  input  logic                                  pop,
  input  logic                                  empty,
  input  logic                                  out_hit,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ppt_pkg::ADDR_W-1:0]            paddr,
  input  logic [ppt_pkg::DATA_W-1:0]            pwdata,
  input  logic [ppt_pkg::DATA_W-1:0]            prdata,
  input  logic                                  pready,
  output int                                    mismatches,
  output int                                    hits_pending
);
  import ppt_pkg::*;

  logic signed [COORD_BITS-1:0] query_x, query_y, prev_x, prev_y;
  logic                         have_prev, hit_flag, want_hit;
  logic [TOL_W-1:0]             tol_q;
  logic                         expected_hits[$];
  int                           mism_cnt = 0;

  function automatic logic segment_within_tol(input longint ax, input longint ay,
                                              input longint bx, input longint by,
                                              input longint qx, input longint qy,
                                              input longint tol);
    longint       vx, vy, wx, wy, dot_vw, len2, cr, dist2, t2;
    logic [127:0] acr, cross_sq, bound;
    vx     = bx - ax;
    vy     = by - ay;
    wx     = qx - ax;
    wy     = qy - ay;
    t2     = tol * tol;
    dot_vw = vx * wx + vy * wy;
    len2   = vx * vx + vy * vy;
    if (dot_vw <= 0 || len2 == 0) begin
      dist2 = wx * wx + wy * wy;
      return dist2 <= t2;
    end
    if (dot_vw >= len2) begin
      dist2 = (qx - bx) * (qx - bx) + (qy - by) * (qy - by);
      return dist2 <= t2;
    end
    cr = vx * wy - vy * wx;
    if (cr < 0) begin
      cr = -cr;
    end
    acr      = cr;
    cross_sq = acr * acr;
    bound    = 128'(t2) * 128'(len2);
    return cross_sq <= bound;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (mism_cnt < 10) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    end
    mism_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      query_x   = '0;
      query_y   = '0;
      prev_x    = '0;
      prev_y    = '0;
      have_prev = 1'b0;
      hit_flag  = 1'b0;
      tol_q     = TOL_RESET;
      expected_hits.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[ADDR_W-1:2] == REG_TOLERANCE) begin
            tol_q = pwdata[TOL_W-1:0];
          end
        end else if (prdata !== {{(DATA_W-TOL_W){1'b0}}, tol_q}) begin
          note_mismatch("tolerance read", tol_q, prdata);
        end
      end
      // A result beat can never belong to an item accepted at the same edge.
      if (pop && !empty) begin
        if (expected_hits.size() == 0) begin
          note_mismatch("unexpected hit beat (expected none)", -1, out_hit);
        end else begin
          want_hit = expected_hits.pop_front();
          if (out_hit !== want_hit) begin
            note_mismatch("hit", want_hit, out_hit);
          end
        end
      end
      if (push && !full) begin
        if (in_cmd == CMD_QUERY) begin
          query_x  = in_coord_x;
          query_y  = in_coord_y;
          hit_flag = 1'b0;
        end else begin
          if (have_prev && segment_within_tol(prev_x, prev_y, in_coord_x, in_coord_y,
                                              query_x, query_y, tol_q)) begin
            hit_flag = 1'b1;
          end
          prev_x    = in_coord_x;
          prev_y    = in_coord_y;
          have_prev = 1'b1;
          if (in_last) begin
            have_prev = 1'b0;
            expected_hits.push_back(hit_flag);
          end
        end
      end
    end
    mismatches   <= mism_cnt;
    hits_pending <= expected_hits.size();
  end

endmodule

/* tb/polyline_proximity_test_unit_tb.sv */
`timescale 1ns / 1ps
module polyline_proximity_test_unit_tb;
  import ppt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam logic [ADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 push       = 1'b0;
  logic                 full;
  logic                 in_cmd     = CMD_QUERY;
  logic signed [CB-1:0] in_coord_x = '0;
  logic signed [CB-1:0] in_coord_y = '0;
  logic                 in_last    = 1'b0;
  logic                 pop        = 1'b0;
  logic                 empty;
  logic                 out_hit;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [ADDR_W-1:0]    paddr      = '0;
  logic [DATA_W-1:0]    pwdata     = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int                   mismatches;
  int                   hits_pending;
  int                   send_idle_pct = 32;
  int                   recv_idle_pct = 74;
  int                   cur_tol       = TOL_RESET;

  polyline_proximity_test_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_cmd(in_cmd), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_last(in_last),
    .pop(pop), .empty(empty), .out_hit(out_hit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ppt_hit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_cmd(in_cmd), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_last(in_last),
    .pop(pop), .empty(empty), .out_hit(out_hit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .hits_pending(hits_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(input logic c, input logic signed [CB-1:0] x,
                           input logic signed [CB-1:0] y, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_cmd     <= c;
    in_coord_x <= x;
    in_coord_y <= y;
    in_last    <= l;
    do @(posedge clk); while (full);
  endtask

  task automatic cfg_access(input logic wr, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TOL_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr) begin
      cur_tol = value;
    end
  endtask

  // Holds the sender off until every hit beat has arrived and the back end has gone quiet.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (hits_pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic random_shapes(input int budget);
    int                   sent, nv, span, sel, off;
    logic signed [CB-1:0] qx, qy, vx, vy;
    logic                 lst;
    sent = 0;
    qx   = '0;
    qy   = '0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        qx = CB'($urandom);
        qy = CB'($urandom);
        send_item(CMD_QUERY, qx, qy, 1'($urandom_range(0, 1)));
        sent++;
      end
      nv   = $urandom_range(1, 6);
      sel  = $urandom_range(0, 9);
      span = (sel < 4) ? cur_tol + 8 : (sel < 7) ? 3 * cur_tol + 16 : (sel == 7) ? 256 : 4096;
      for (int k = 0; k < nv; k++) begin
        if (sel == 9) begin
          vx = CB'($urandom);
          vy = CB'($urandom);
        end else begin
          off = int'($urandom_range(0, 2 * span)) - span;
          vx  = CB'(qx + off);
          off = int'($urandom_range(0, 2 * span)) - span;
          vy  = CB'(qy + off);
        end
        lst = (k == nv - 1);
        if ($urandom_range(0, 99) < 4) begin
          lst = ~lst;
        end
        send_item(CMD_VERTEX, vx, vy, lst);
        sent++;
        if ($urandom_range(0, 99) < 3) begin
          qx = CB'($urandom);
          qy = CB'($urandom);
          send_item(CMD_QUERY, qx, qy, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, 0);

    send_item(CMD_VERTEX, 0, 0, 1'b1);
    send_item(CMD_QUERY, 0, 0, 1'b1);
    send_item(CMD_VERTEX, -50, 32, 1'b0);
    send_item(CMD_VERTEX, 50, 32, 1'b1);
    send_item(CMD_VERTEX, 0, 0, 1'b1);
    send_item(CMD_QUERY, 0, 0, 1'b0);
    send_item(CMD_VERTEX, -50, 33, 1'b0);
    send_item(CMD_VERTEX, 50, 33, 1'b0);
    send_item(CMD_VERTEX, 50, 33, 1'b0);
    send_item(CMD_VERTEX, 32, 0, 1'b1);
    send_item(CMD_QUERY, 1000, 1000, 1'b0);
    send_item(CMD_VERTEX, 1020, 1000, 1'b0);
    send_item(CMD_VERTEX, 1020, 1000, 1'b1);
    send_item(CMD_QUERY, 0, 0, 1'b0);
    send_item(CMD_VERTEX, 40, 0, 1'b0);
    send_item(CMD_VERTEX, 100, 0, 1'b1);
    send_item(CMD_QUERY, -32768, -32768, 1'b0);
    send_item(CMD_VERTEX, 32767, 32767, 1'b0);
    send_item(CMD_VERTEX, -32768, 32767, 1'b0);
    send_item(CMD_QUERY, 32767, -32768, 1'b1);
    send_item(CMD_VERTEX, -32768, -32768, 1'b1);
    send_item(CMD_QUERY, 0, 0, 1'b0);
    send_item(CMD_VERTEX, -32768, 32767, 1'b0);
    send_item(CMD_VERTEX, 32767, -32768, 1'b1);

    settle();
    cfg_access(1'b1, $urandom_range(1, 4094));
    cfg_access(1'b0, 0);
    random_shapes(100);
    settle();
    cfg_access(1'b1, 0);
    random_shapes(40);

    settle();
    send_idle_pct = 74;
    recv_idle_pct = 32;
    cfg_access(1'b1, 4095);
    cfg_access(1'b0, 0);
    random_shapes(130);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_access(1'b1, 8);
    cfg_access(1'b0, 0);
    random_shapes(130);

    settle();
    if (mismatches == 0 && hits_pending == 0) begin
      $display("PASS polyline_proximity_test_unit");
    end else begin
      $display("FAIL polyline_proximity_test_unit");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL polyline_proximity_test_unit");
    $finish;
  end

endmodule

/* polyline_proximity_test_unit.f */
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_front.sv
rtl/ppt_queue.sv
rtl/ppt_back.sv
rtl/polyline_proximity_test_unit.sv
tb/ppt_hit_checker.sv
tb/polyline_proximity_test_unit_tb.sv
